// File: rtl/core/tfna_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the triangle face normal assignment block.
// No dependencies; used by every module under rtl/core.
package tfna_pkg;

  localparam int unsigned CAPACITY_DEF = 65536;
  localparam int unsigned IDX_W        = 17;
  localparam int unsigned COORD_W      = 16;
  localparam int unsigned DIFF_W       = 17;
  localparam int unsigned CROSS_W      = 34;
  localparam int unsigned MAG_W        = 33;
  localparam int unsigned SQ_W         = 66;
  localparam int unsigned LEN_W        = 68;
  localparam int unsigned ACC_W        = 102;
  localparam int unsigned BACC_W       = 84;
  localparam int unsigned ROOT_W       = 15;
  localparam int unsigned IN_W         = 200;
  localparam int unsigned OUT_W        = 104;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_ROOT,
    ST_DONE
  } state_t;

  // One multiplier step per code: cross-product terms, then partial squares.
  typedef enum logic [3:0] {
    SP_NX_A, SP_NX_B, SP_NY_A, SP_NY_B, SP_NZ_A, SP_NZ_B,
    SP_X_LL, SP_X_HL, SP_X_HH,
    SP_Y_LL, SP_Y_HL, SP_Y_HH,
    SP_Z_LL, SP_Z_HL, SP_Z_HH
  } step_t;

  localparam logic [3:0] MUL_LAST  = 4'd14;
  localparam logic [3:0] ROOT_LAST = 4'd14;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    step_t      mul_step;
    logic       acc_en;
    step_t      acc_step;
    logic       sum_en;
    logic       root_en;
    logic [3:0] root_bit;
  } cmd_t;

endpackage

// File: rtl/core/tfna_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine for the face normal block.
// Depends on tfna_pkg; drives the command struct of tfna_dp.
module tfna_ctrl
  import tfna_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  input  logic in_need,
  input  logic out_free,
  output logic in_ready,
  output logic done_load,
  output cmd_t cmd
);

  state_t     state, state_next;
  logic [3:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    in_ready     = 1'b0;
    done_load    = 1'b0;
    cmd          = '0;
    cmd.mul_step = step_t'(cnt);
    cmd.acc_step = step_t'(cnt - 4'd1);
    cmd.root_bit = ROOT_LAST - cnt;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_fire;
        cnt_next = '0;
        if (in_fire) begin
          state_next = in_need ? ST_MUL : ST_DONE;
        end
      end
      ST_MUL: begin
        // Multiply issues on counts 0..14; each product accumulates in the cycle after it issues.
        cmd.mul_en = (cnt <= MUL_LAST);
        cmd.acc_en = (cnt != 4'd0);
        if (cnt > MUL_LAST) begin
          state_next = ST_SUM;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 4'd1;
        end
      end
      ST_SUM: begin
        cmd.sum_en = 1'b1;
        state_next = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_en = 1'b1;
        if (cnt == ROOT_LAST) begin
          state_next = ST_DONE;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 4'd1;
        end
      end
      ST_DONE: begin
        done_load = out_free;
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: rtl/core/tfna_dp.sv
`timescale 1ns / 1ps
// Datapath: edge vectors, cross product and squared length on one shared
// multiplier, then three bit-serial root/divide lanes. Depends on tfna_pkg.
module tfna_dp
  import tfna_pkg::*;
(
  input  logic                        clk,
  input  cmd_t                        cmd,
  input  logic signed [COORD_W-1:0]   a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
  output logic signed [COORD_W-1:0]   normal_x, normal_y, normal_z,
  output logic                        degenerate
);

  logic signed [DIFF_W-1:0]  d1x, d1y, d1z, d2x, d2y, d2z;
  logic signed [18:0]        op_a, op_b;
  logic signed [37:0]        prod;
  logic signed [CROSS_W-1:0] nv [3];
  logic [MAG_W-1:0]          mag [3];
  logic [SQ_W-1:0]           sqv [3];
  logic [LEN_W-1:0]          len2;
  logic [ACC_W-1:0]          acc_a [3];
  logic [BACC_W-1:0]         acc_b [3];
  logic [ROOT_W-1:0]         root [3];
  logic [ACC_W-1:0]          trial [3];
  logic [ACC_W-1:0]          rhs [3];
  logic                      fits [3];
  logic signed [COORD_W-1:0] comp [3];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      d1x <= DIFF_W'(c_x) - DIFF_W'(b_x);
      d1y <= DIFF_W'(c_y) - DIFF_W'(b_y);
      d1z <= DIFF_W'(c_z) - DIFF_W'(b_z);
      d2x <= DIFF_W'(b_x) - DIFF_W'(a_x);
      d2y <= DIFF_W'(b_y) - DIFF_W'(a_y);
      d2z <= DIFF_W'(b_z) - DIFF_W'(a_z);
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_mag
    assign mag[k] = nv[k][CROSS_W-1] ? MAG_W'(-nv[k]) : MAG_W'(nv[k]);
  end

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (cmd.mul_step)
      SP_NX_A: begin op_a = 19'(d1y); op_b = 19'(d2z); end
      SP_NX_B: begin op_a = 19'(d1z); op_b = 19'(d2y); end
      SP_NY_A: begin op_a = 19'(d1z); op_b = 19'(d2x); end
      SP_NY_B: begin op_a = 19'(d1x); op_b = 19'(d2z); end
      SP_NZ_A: begin op_a = 19'(d1x); op_b = 19'(d2y); end
      SP_NZ_B: begin op_a = 19'(d1y); op_b = 19'(d2x); end
      SP_X_LL: begin op_a = {1'b0, mag[0][17:0]};   op_b = {1'b0, mag[0][17:0]}; end
      SP_X_HL: begin op_a = {4'b0, mag[0][32:18]};  op_b = {1'b0, mag[0][17:0]}; end
      SP_X_HH: begin op_a = {4'b0, mag[0][32:18]};  op_b = {4'b0, mag[0][32:18]}; end
      SP_Y_LL: begin op_a = {1'b0, mag[1][17:0]};   op_b = {1'b0, mag[1][17:0]}; end
      SP_Y_HL: begin op_a = {4'b0, mag[1][32:18]};  op_b = {1'b0, mag[1][17:0]}; end
      SP_Y_HH: begin op_a = {4'b0, mag[1][32:18]};  op_b = {4'b0, mag[1][32:18]}; end
      SP_Z_LL: begin op_a = {1'b0, mag[2][17:0]};   op_b = {1'b0, mag[2][17:0]}; end
      SP_Z_HL: begin op_a = {4'b0, mag[2][32:18]};  op_b = {1'b0, mag[2][17:0]}; end
      SP_Z_HH: begin op_a = {4'b0, mag[2][32:18]};  op_b = {4'b0, mag[2][32:18]}; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= op_a * op_b;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_en) begin
      unique case (cmd.acc_step)
        SP_NX_A: nv[0] <= CROSS_W'(prod);
        SP_NX_B: nv[0] <= nv[0] - CROSS_W'(prod);
        SP_NY_A: nv[1] <= CROSS_W'(prod);
        SP_NY_B: nv[1] <= nv[1] - CROSS_W'(prod);
        SP_NZ_A: nv[2] <= CROSS_W'(prod);
        SP_NZ_B: nv[2] <= nv[2] - CROSS_W'(prod);
        SP_X_LL: sqv[0] <= SQ_W'(prod[35:0]);
        SP_X_HL: sqv[0] <= sqv[0] + (SQ_W'(prod[33:0]) << 19);
        SP_X_HH: sqv[0] <= sqv[0] + (SQ_W'(prod[29:0]) << 36);
        SP_Y_LL: sqv[1] <= SQ_W'(prod[35:0]);
        SP_Y_HL: sqv[1] <= sqv[1] + (SQ_W'(prod[33:0]) << 19);
        SP_Y_HH: sqv[1] <= sqv[1] + (SQ_W'(prod[29:0]) << 36);
        SP_Z_LL: sqv[2] <= SQ_W'(prod[35:0]);
        SP_Z_HL: sqv[2] <= sqv[2] + (SQ_W'(prod[33:0]) << 19);
        SP_Z_HH: sqv[2] <= sqv[2] + (SQ_W'(prod[29:0]) << 36);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_en) begin
      len2 <= LEN_W'(sqv[0]) + LEN_W'(sqv[1]) + LEN_W'(sqv[2]);
    end
  end

  // Each lane finds the largest m with m*m*len2 <= mag*mag*2^28, one bit
  // per cycle, keeping m*m*len2 and m*len2 so no wide multiply is needed.
  for (genvar k = 0; k < 3; k++) begin : g_lane
    assign trial[k] = acc_a[k] + (ACC_W'(acc_b[k]) << (cmd.root_bit + 4'd1))
                    + (ACC_W'(len2) << {cmd.root_bit, 1'b0});
    assign rhs[k]   = ACC_W'(sqv[k]) << 28;
    assign fits[k]  = (trial[k] <= rhs[k]);

    always_ff @(posedge clk) begin
      if (cmd.sum_en) begin
        acc_a[k] <= '0;
        acc_b[k] <= '0;
        root[k]  <= '0;
      end else if (cmd.root_en && fits[k]) begin
        acc_a[k] <= trial[k];
        acc_b[k] <= acc_b[k] + (BACC_W'(len2) << cmd.root_bit);
        root[k]  <= root[k] | (ROOT_W'(1) << cmd.root_bit);
      end
    end

    assign comp[k] = degenerate ? '0 :
                     (nv[k][CROSS_W-1] ? -$signed({1'b0, root[k]}) : $signed({1'b0, root[k]}));
  end

  assign degenerate = (len2 == '0);
  assign normal_x   = comp[0];
  assign normal_y   = comp[1];
  assign normal_z   = comp[2];

endmodule

// File: rtl/core/triangle_face_normal_assign_top.sv
`timescale 1ns / 1ps
// Top level of the triangle face normal assignment block.
// Depends on tfna_pkg, tfna_ctrl and tfna_dp.
//
// Usage: one triangle face arrives per slave-side transaction (s_tvalid,
// s_tready, s_tdata) and one result leaves per master-side transaction
// (m_tvalid, m_tready, m_tdata). Only one face is in work at a time.
// A face whose three normal indices are all set goes from acceptance straight
// to the hand-off state, which loads the result register once the output
// register is free; the block then returns to idle for the next face. A face
// with an unset index first passes the single shared 19x19 multiplier (cross
// product and partial squares), then the squared-length sum, then the
// bit-serial root/divide lanes, one quotient bit per cycle, and then the
// hand-off state. A new face is accepted only after the last is handed off.
// The result sits in an output register, so a new face is accepted while the
// previous result still waits for m_tready; if the receiver stalls, the block
// finishes the next face and then holds it until the output register frees.
// Reset clears the handshake state and sets the free-index counter and the
// loaded_normal_count register to zero. Writing cfg_wdata with cfg_wen
// reloads the counter, capped at NORMAL_CAPACITY.
module triangle_face_normal_assign_top
  import tfna_pkg::*;
#(
  parameter int unsigned NORMAL_CAPACITY = CAPACITY_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (16 each), first_normal_in,
  // second_normal_in, third_normal_in (17 each), zero pad
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // normal_x, normal_y, normal_z, first_normal_out, second_normal_out,
  // third_normal_out (16 each), normal_made, degenerate, store_full, zero pad
  output logic [OUT_W-1:0] m_tdata,
  input  logic             cfg_wen,
  input  logic [IDX_W-1:0] cfg_wdata
);

  localparam logic [IDX_W-1:0] CAP      = IDX_W'(NORMAL_CAPACITY);
  localparam logic [15:0]      LAST_IDX = 16'(NORMAL_CAPACITY - 1);

  logic             in_fire, in_need, out_free, done_load;
  cmd_t             cmd;
  logic [IDX_W-1:0] loaded_normal_count;
  logic [IDX_W-1:0] next_free_normal;
  logic [2:0]       unset, unset_in;
  logic [15:0]      idx_in [3];
  logic [15:0]      idx_hold [3];
  logic             need;
  logic             full;
  logic [15:0]      new_idx;
  logic signed [COORD_W-1:0] nx, ny, nz;
  logic             degen;

  assign in_fire  = s_tvalid && s_tready;
  assign unset_in = {s_tdata[194], s_tdata[177], s_tdata[160]};
  assign in_need  = |unset_in;
  assign out_free = !m_tvalid || m_tready;

  tfna_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .in_need   (in_need),
    .out_free  (out_free),
    .in_ready  (s_tready),
    .done_load (done_load),
    .cmd       (cmd)
  );

  tfna_dp u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .a_x        (s_tdata[15:0]),
    .a_y        (s_tdata[31:16]),
    .a_z        (s_tdata[47:32]),
    .b_x        (s_tdata[63:48]),
    .b_y        (s_tdata[79:64]),
    .b_z        (s_tdata[95:80]),
    .c_x        (s_tdata[111:96]),
    .c_y        (s_tdata[127:112]),
    .c_z        (s_tdata[143:128]),
    .normal_x   (nx),
    .normal_y   (ny),
    .normal_z   (nz),
    .degenerate (degen)
  );

  // Index fields of the face are held here for the whole computation.
  assign idx_in[0] = s_tdata[159:144];
  assign idx_in[1] = s_tdata[176:161];
  assign idx_in[2] = s_tdata[193:178];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      unset    <= unset_in;
      need     <= in_need;
      idx_hold <= idx_in;
    end
  end

  // The store is full once the counter reaches the capacity; then every
  // unset slot gets the last index and the counter stays put.
  assign full    = (next_free_normal >= CAP);
  assign new_idx = full ? LAST_IDX : next_free_normal[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_normal_count <= '0;
      next_free_normal    <= '0;
    end else if (cfg_wen) begin
      loaded_normal_count <= cfg_wdata;
      next_free_normal    <= (cfg_wdata > CAP) ? CAP : cfg_wdata;
    end else if (done_load && need && !full) begin
      next_free_normal <= next_free_normal + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_load) begin
      m_tdata[15:0]    <= need ? nx : '0;
      m_tdata[31:16]   <= need ? ny : '0;
      m_tdata[47:32]   <= need ? nz : '0;
      m_tdata[63:48]   <= unset[0] ? new_idx : idx_hold[0];
      m_tdata[79:64]   <= unset[1] ? new_idx : idx_hold[1];
      m_tdata[95:80]   <= unset[2] ? new_idx : idx_hold[2];
      m_tdata[96]      <= need;
      m_tdata[97]      <= need && degen;
      m_tdata[98]      <= need && full;
      m_tdata[103:99]  <= '0;
    end
  end

  // Only one face is in work at a time.
  a_one_face: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !s_tready)
    else $error("face accepted while another is in work");

  // A degenerate result is always a made normal.
  a_degen_made: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[97] |-> m_tdata[96])
    else $error("degenerate flag without a made normal");

  // The counter never passes the capacity.
  a_cap: assert property (@(posedge clk) disable iff (rst)
    next_free_normal <= CAP)
    else $error("free-index counter beyond capacity");

  // A result loads only when the output register can take it.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("pending result overwritten");

endmodule

// File: tb/sv/tb_triangle_face_normal_assign_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for triangle_face_normal_assign_top.
// Depends on tfna_pkg and the RTL of the block; it reads no files.
module tb_triangle_face_normal_assign_top
  import tfna_pkg::*;
();

  localparam int unsigned CAP         = 65536;
  localparam int          QUIET_LIMIT = 6000;
  localparam int          DRAIN_WAIT  = 60;
  localparam logic [16:0] IDX_UNSET   = 17'h1FFFF;

  typedef struct packed {
    logic        full;
    logic        degen;
    logic        made;
    logic [15:0] idx_c;
    logic [15:0] idx_b;
    logic [15:0] idx_a;
    logic [15:0] nz;
    logic [15:0] ny;
    logic [15:0] nx;
  } face_result_t;

  typedef struct {
    logic signed [15:0] v[9];
    logic        [16:0] idx[3];
  } face_t;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata;
  logic             m_tvalid;
  logic             m_tready;
  logic [OUT_W-1:0] m_tdata;
  logic             cfg_wen;
  logic [IDX_W-1:0] cfg_wdata;

  // Model state: the free-index counter that the block keeps.
  logic [16:0]  free_index;
  face_result_t pending_results[$];
  int           mismatches;
  int           faces_sent;
  int           results_seen;
  int           full_seen;
  int           degen_seen;
  int           quiet_cycles;
  int           in_gap_mode;
  int           out_stall_mode;

  triangle_face_normal_assign_top u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // trunc(c * 2^14 / sqrt(len2)), found one quotient bit at a time by comparing squares.
  function automatic logic [15:0] unit_part(longint c, logic [127:0] len2);
    logic [127:0] mag;
    logic [127:0] rhs;
    logic [127:0] m;
    logic [127:0] t;
    mag = (c < 0) ? 128'(-c) : 128'(c);
    rhs = (mag * mag) << 28;
    m = '0;
    for (int b = 14; b >= 0; b--) begin
      t = m | (128'd1 << b);
      if (len2 * t * t <= rhs) m = t;
    end
    if (c < 0) m = -m;
    return m[15:0];
  endfunction

  // Works out the result of one face and advances the free-index counter.
  function automatic face_result_t assign_face_normal(face_t f);
    face_result_t r;
    logic         any_unset;
    longint       d1[3];
    longint       d2[3];
    longint       n[3];
    logic [127:0] len2;
    logic [15:0]  idx;
    r = '0;
    r.idx_a = f.idx[0][15:0];
    r.idx_b = f.idx[1][15:0];
    r.idx_c = f.idx[2][15:0];
    // Any index with its sign bit set counts as unset, not just -1.
    any_unset = f.idx[0][16] | f.idx[1][16] | f.idx[2][16];
    if (!any_unset) return r;
    for (int i = 0; i < 3; i++) begin
      d1[i] = longint'(f.v[6 + i]) - longint'(f.v[3 + i]);
      d2[i] = longint'(f.v[3 + i]) - longint'(f.v[i]);
    end
    n[0] = d1[1] * d2[2] - d1[2] * d2[1];
    n[1] = d1[2] * d2[0] - d1[0] * d2[2];
    n[2] = d1[0] * d2[1] - d1[1] * d2[0];
    len2 = '0;
    for (int i = 0; i < 3; i++) len2 += 128'(n[i] < 0 ? -n[i] : n[i]) ** 2;
    r.made = 1'b1;
    if (len2 == 0) begin
      r.degen = 1'b1;
    end else begin
      r.nx = unit_part(n[0], len2);
      r.ny = unit_part(n[1], len2);
      r.nz = unit_part(n[2], len2);
    end
    if (free_index >= CAP) begin
      r.full = 1'b1;
      idx = 16'(CAP - 1);
    end else begin
      idx = free_index[15:0];
      free_index++;
    end
    if (f.idx[0][16]) r.idx_a = idx;
    if (f.idx[1][16]) r.idx_b = idx;
    if (f.idx[2][16]) r.idx_c = idx;
    return r;
  endfunction

  // Mostly short gaps, a few long ones; mode 0 means no gaps at all.
  function automatic int pick_gap(int mode);
    int r;
    if (mode == 0) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 94) return $urandom_range(3, 1);
    return $urandom_range(70, 15);
  endfunction

  // The receiver toggles tready at random, with its own stall pattern.
  always @(posedge clk) begin
    if (rst || out_stall_mode == 0) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= (pick_gap(out_stall_mode) == 0);
    end
  end

  // Checks each result transaction against the oldest pending expectation.
  always @(posedge clk) begin
    face_result_t got;
    face_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = face_result_t'(m_tdata[98:0]);
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %h", got);
      end else begin
        want = pending_results.pop_front();
        if (want.full) full_seen++;
        if (want.degen) degen_seen++;
        if (got.nx !== want.nx || got.ny !== want.ny || got.nz !== want.nz ||
            got.idx_a !== want.idx_a || got.idx_b !== want.idx_b ||
            got.idx_c !== want.idx_c || got.made !== want.made ||
            got.degen !== want.degen || got.full !== want.full) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR: result %0d: normal exp %h %h %h got %h %h %h", results_seen,
                     want.nx, want.ny, want.nz, got.nx, got.ny, got.nz);
            $display("  index exp %h %h %h got %h %h %h; made/degen/full exp %b%b%b got %b%b%b",
                     want.idx_a, want.idx_b, want.idx_c, got.idx_a, got.idx_b,
                     got.idx_c, want.made, want.degen, want.full, got.made,
                     got.degen, got.full);
          end
        end
      end
    end
  end

  // Watchdog: the run ends if no transaction moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("ERROR: watchdog expired with %0d results pending", pending_results.size());
      $display("triangle_face_normal_assign_top: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Sends one face, records its expected result at acceptance, then idles for the gap that pick_gap chooses, if any.
  task automatic send_face(face_t f);
    logic [IN_W-1:0] d;
    int              gap;
    d = '0;
    for (int i = 0; i < 9; i++) d[16*i +: 16] = f.v[i];
    for (int i = 0; i < 3; i++) d[144 + 17*i +: 17] = f.idx[i];
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    do @(posedge clk); while (!s_tready);
    pending_results = {pending_results, assign_face_normal(f)};
    faces_sent++;
    gap = pick_gap(in_gap_mode);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Lets every pending result drain, plus the worst-case latency of a face in work.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_loaded_count(logic [16:0] value);
    wait_idle();
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    free_index = (value > CAP) ? 17'(CAP) : value;
  endtask

  function automatic face_t make_face(int c0, int c1, int c2, int c3, int c4, int c5,
                                      int c6, int c7, int c8, logic [16:0] i0,
                                      logic [16:0] i1, logic [16:0] i2);
    face_t f;
    f.v[0] = 16'(c0); f.v[1] = 16'(c1); f.v[2] = 16'(c2);
    f.v[3] = 16'(c3); f.v[4] = 16'(c4); f.v[5] = 16'(c5);
    f.v[6] = 16'(c6); f.v[7] = 16'(c7); f.v[8] = 16'(c8);
    f.idx[0] = i0; f.idx[1] = i1; f.idx[2] = i2;
    return f;
  endfunction

  function automatic logic [16:0] random_index();
    int r;
    r = $urandom_range(99);
    if (r < 45) return IDX_UNSET;
    if (r < 55) return {1'b1, 16'($urandom)};
    return {1'b0, 16'($urandom)};
  endfunction

  // Random faces: full range, small triangles, and repeated or collinear corners.
  function automatic face_t random_face();
    face_t f;
    int    kind;
    int    k;
    kind = $urandom_range(9);
    for (int i = 0; i < 9; i++) begin
      if (kind < 5) f.v[i] = 16'($urandom);
      else f.v[i] = 16'($urandom_range(1024) - 512);
    end
    if (kind == 9) begin
      k = $urandom_range(3, 1);
      for (int i = 0; i < 3; i++)
        f.v[6 + i] = 16'(f.v[3 + i] + k * (f.v[3 + i] - f.v[i]));
    end else if (kind == 8) begin
      for (int i = 0; i < 3; i++) f.v[3 + i] = f.v[i];
    end
    for (int i = 0; i < 3; i++) f.idx[i] = random_index();
    return f;
  endfunction

  // Extremes of the coordinates and indices, each unset slot alone, sign-bit indices.
  task automatic test_directed();
    in_gap_mode = 0;
    out_stall_mode = 0;
    send_face(make_face(0, 0, 0, 256, 0, 0, 0, 256, 0, 17'd1, 17'd2, 17'd3));
    send_face(make_face(0, 0, 0, 256, 0, 0, 0, 256, 0, IDX_UNSET, IDX_UNSET, IDX_UNSET));
    send_face(make_face(0, 0, 0, 0, 256, 0, 0, 0, 256, IDX_UNSET, 17'd65535, 17'd0));
    send_face(make_face(0, 0, 0, 0, 0, 256, 256, 0, 0, 17'd7, IDX_UNSET, 17'd9));
    send_face(make_face(5, 5, 5, 9, -3, 1, -2, 8, 4, 17'd7, 17'd8, IDX_UNSET));
    send_face(make_face(1, 2, 3, 4, 5, 6, 9, 1, 2, 17'h10000, 17'h1ABCD, 17'd0));
    // Identical corners and collinear corners give a zero-length cross product.
    send_face(make_face(100, -50, 7, 100, -50, 7, 100, -50, 7, IDX_UNSET, 17'd1, 17'd2));
    send_face(make_face(0, 0, 0, 10, 20, 30, 20, 40, 60, IDX_UNSET, IDX_UNSET, 17'd2));
    send_face(make_face(-32768, -32768, -32768, 32767, -32768, 32767, -32768, 32767, 32767,
                        IDX_UNSET, IDX_UNSET, IDX_UNSET));
    send_face(make_face(32767, 32767, 32767, -32768, 32767, -32768, 32767, -32768, -32768,
                        IDX_UNSET, 17'd65535, IDX_UNSET));
    send_face(make_face(32767, -32768, 0, -32768, 32767, 0, 0, 0, 32767,
                        17'd65535, 17'd65535, IDX_UNSET));
    send_face(make_face(0, 0, 0, 1, 0, 0, 0, 1, 0, IDX_UNSET, 17'd0, 17'd0));
    send_face(make_face(-1, -1, -1, 0, 0, 0, 1, 2, 1, 17'h1FFFE, 17'd4, 17'd5));
    send_face(make_face(-32768, 0, 0, 32767, 0, 0, -32768, 0, 0, IDX_UNSET, 17'd1, 17'd1));
    send_face(make_face(32767, 32767, 32767, 32767, 32767, 32767, 0, 0, 0,
                        17'd65535, 17'd65535, 17'd65535));
    wait_idle();
  endtask

  // Counter runs into the capacity: the last free index, then saturation.
  task automatic test_store_full();
    write_loaded_count(17'(CAP - 2));
    for (int i = 0; i < 4; i++)
      send_face(make_face(0, 0, 0, 256 + i, 0, 0, 0, 256, 0, IDX_UNSET, 17'd3, IDX_UNSET));
    send_face(make_face(0, 0, 0, 0, 0, 0, 0, 0, 0, IDX_UNSET, IDX_UNSET, IDX_UNSET));
    send_face(make_face(0, 0, 0, 1, 0, 0, 0, 1, 0, 17'd11, 17'd12, 17'd13));
    write_loaded_count(17'(CAP));
    send_face(make_face(0, 0, 0, 3, 1, 0, 0, 2, 5, 17'd1, IDX_UNSET, 17'd2));
    write_loaded_count(17'h1FFFF);
    send_face(make_face(0, 0, 0, 3, 1, 0, 0, 2, 5, IDX_UNSET, 17'd1, 17'd2));
    write_loaded_count(17'd0);
    send_face(make_face(0, 0, 0, 3, 1, 0, 0, 2, 5, IDX_UNSET, 17'd1, 17'd2));
    wait_idle();
  endtask

  // Random phases, each with its own register value and idle pattern on both sides.
  task automatic test_random(int count);
    int phase_len;
    int r;
    int done;
    done = 0;
    while (done < count) begin
      r = $urandom_range(5);
      case (r)
        0: write_loaded_count(17'd0);
        1: write_loaded_count(17'(CAP - $urandom_range(40)));
        2: write_loaded_count(17'($urandom_range(131071)));
        default: write_loaded_count(17'($urandom_range(65535)));
      endcase
      in_gap_mode = $urandom_range(2);
      out_stall_mode = $urandom_range(2);
      phase_len = $urandom_range(200, 60);
      for (int i = 0; i < phase_len && done < count; i++) begin
        send_face(random_face());
        done++;
      end
    end
    wait_idle();
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    m_tready = 1'b1;
    in_gap_mode = 0;
    out_stall_mode = 0;
    free_index = '0;
    mismatches = 0;
    faces_sent = 0;
    results_seen = 0;
    full_seen = 0;
    degen_seen = 0;
    quiet_cycles = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_store_full();
    test_random(1330);

    $display("Summary: %0d faces in, %0d results out, %0d degenerate, %0d with store full.",
             faces_sent, results_seen, degen_seen, full_seen);
    $display("Register settings swept from zero to above capacity; %0d mismatches.", mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("triangle_face_normal_assign_top: match");
    end else begin
      $display("triangle_face_normal_assign_top: mismatch");
    end
    $finish;
  end

endmodule
